// File: hw/rtl/ufpd_pkg.sv
// Package for the form pair decoder: character codes, byte classes and the
// queue entry that passes from the front end to the back end.
// No dependencies.
package ufpd_pkg;

   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_EQUAL,
      CLS_AMP,
      CLS_PERCENT,
      CLS_PLUS
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     in_byte;
      logic           is_last;
      byte_class_type cls;
      logic [3:0]     digit;
   } item_type;

   // Hexadecimal digit value; any byte that is not a hex digit counts as zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] b);
      logic [3:0] val;
      val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         val = b[3:0];
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         val = 4'(b[3:0] + 4'd9);
      end
      return val;
   endfunction

endpackage

// File: hw/rtl/ufpd_req_if.sv
// Request channel of the form pair decoder: one raw byte per transaction.
// No dependencies.
interface ufpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source(output valid, in_byte, is_last, input ready);
   modport sink(input valid, in_byte, is_last, output ready);
endinterface

// File: hw/rtl/ufpd_rsp_if.sv
// Response channel of the form pair decoder: one decoded character and/or
// pair boundary per transaction.
// No dependencies.
interface ufpd_rsp_if;
   logic       valid;
   logic       ready;
   logic       char_valid;
   logic [7:0] char_out;
   logic       in_value;
   logic       pair_end;

   modport source(output valid, char_valid, char_out, in_value, pair_end, input ready);
   modport sink(input valid, char_valid, char_out, in_value, pair_end, output ready);
endinterface

// File: hw/rtl/url_form_pair_decoder.sv
// Decoder for form-encoded parameter strings, one byte per transaction. The
// block takes one byte every clock cycle while the queue has room and returns
// at most one response per byte, carrying the decoded character with its
// key/value tag and/or a pair end; bytes that yield nothing (an equals sign in
// the key, a percent sign, the first escape digit) give no response. With the
// queue empty and the response side ready, an accepted byte goes into the
// queue and its response is then registered in the response register. The
// rate of one byte per cycle while neither side stalls is set by the decode
// step in the back end, and a queue of QUEUE_DEPTH entries between the
// classifying front end and the back end lets each side stall on its own.
// Depends on ufpd_pkg, ufpd_req_if, ufpd_rsp_if, ufpd_front, ufpd_queue and
// ufpd_back.
module url_form_pair_decoder #(
   parameter int QUEUE_DEPTH = ufpd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   ufpd_req_if.sink   req_if,
   ufpd_rsp_if.source rsp_if
);

   ufpd_pkg::item_type push_item;
   logic               push_valid;
   logic               push_ready;
   ufpd_pkg::item_type pop_item;
   logic               pop_valid;
   logic               pop_ready;

   ufpd_front u_front (
      .req_if     (req_if),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   ufpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   ufpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

// File: hw/rtl/ufpd_front.sv
// Front end of the form pair decoder: accepts request transactions and
// classifies each byte for the back end.
// Depends on ufpd_pkg and ufpd_req_if.
module ufpd_front (
   ufpd_req_if.sink          req_if,
   output ufpd_pkg::item_type push_item,
   output logic              push_valid,
   input  logic              push_ready
);

   ufpd_pkg::byte_class_type cls;

   always_comb begin
      unique case (req_if.in_byte)
         ufpd_pkg::CH_EQUAL:   cls = ufpd_pkg::CLS_EQUAL;
         ufpd_pkg::CH_AMP:     cls = ufpd_pkg::CLS_AMP;
         ufpd_pkg::CH_PERCENT: cls = ufpd_pkg::CLS_PERCENT;
         ufpd_pkg::CH_PLUS:    cls = ufpd_pkg::CLS_PLUS;
         default:              cls = ufpd_pkg::CLS_OTHER;
      endcase
   end

   always_comb begin
      push_item.in_byte = req_if.in_byte;
      push_item.is_last = req_if.is_last;
      push_item.cls     = cls;
      push_item.digit   = ufpd_pkg::hex_digit(req_if.in_byte);
   end

   assign push_valid   = req_if.valid;
   assign req_if.ready = push_ready;

endmodule

// File: hw/rtl/ufpd_queue.sv
// Short queue of classified bytes between the front and back ends.
// Depends on ufpd_pkg.
module ufpd_queue #(
   parameter int DEPTH = ufpd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  ufpd_pkg::item_type push_item,
   input  logic               push_valid,
   output logic               push_ready,
   output ufpd_pkg::item_type pop_item,
   output logic               pop_valid,
   input  logic               pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ufpd_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push_fire && !pop_fire) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop_fire && !push_fire) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Queue fill count exceeds its depth.");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("Queue fill count did not follow a lone push.");

endmodule

// File: hw/rtl/ufpd_back.sv
// Back end of the form pair decoder: holds the phase and escape state,
// decodes each queued byte and registers the response transaction.
// Depends on ufpd_pkg and ufpd_rsp_if.
module ufpd_back (
   input  logic               clock,
   input  logic               reset,
   input  ufpd_pkg::item_type pop_item,
   input  logic               pop_valid,
   output logic               pop_ready,
   ufpd_rsp_if.source         rsp_if
);

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_FIRST,
      ESC_SECOND
   } esc_type;

   logic       value_phase_ff, value_phase_in;
   esc_type    esc_ff, esc_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       key_has_chars_ff, key_has_chars_in;
   logic       rsp_valid_ff;
   logic       char_valid_ff;
   logic [7:0] char_out_ff;
   logic       in_value_ff;
   logic       pair_end_ff;
   logic       emit;
   logic       pair;
   logic [7:0] ch;
   logic       tag;
   logic       pop_fire;

   assign pop_ready = !rsp_valid_ff || rsp_if.ready;
   assign pop_fire  = pop_valid && pop_ready;

   always_comb begin
      value_phase_in   = value_phase_ff;
      esc_in           = esc_ff;
      high_nibble_in   = high_nibble_ff;
      key_has_chars_in = key_has_chars_ff;
      emit             = 1'b0;
      pair             = 1'b0;
      ch               = '0;
      tag              = 1'b0;
      if (!value_phase_ff && pop_item.cls == ufpd_pkg::CLS_EQUAL) begin
         value_phase_in = 1'b1;
      end else if (pop_item.cls == ufpd_pkg::CLS_AMP) begin
         value_phase_in   = 1'b0;
         key_has_chars_in = 1'b0;
         pair             = 1'b1;
      end else if (pop_item.cls == ufpd_pkg::CLS_PERCENT) begin
         esc_in = ESC_FIRST;
      end else if (esc_ff == ESC_FIRST) begin
         high_nibble_in = pop_item.digit;
         esc_in         = ESC_SECOND;
      end else begin
         if (esc_ff == ESC_SECOND) begin
            ch     = {high_nibble_ff, pop_item.digit};
            esc_in = ESC_NONE;
         end else if (pop_item.cls == ufpd_pkg::CLS_PLUS) begin
            ch = ufpd_pkg::CH_SPACE;
         end else begin
            ch = pop_item.in_byte;
         end
         emit = 1'b1;
         tag  = value_phase_ff;
         if (!value_phase_ff) begin
            key_has_chars_in = 1'b1;
         end
      end
      // The last byte also closes a pair when its key is not empty; an ampersand closes one in any case.
      if (pop_item.is_last) begin
         if (key_has_chars_in) begin
            pair = 1'b1;
         end
         value_phase_in   = 1'b0;
         esc_in           = ESC_NONE;
         high_nibble_in   = '0;
         key_has_chars_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_phase_ff   <= 1'b0;
         esc_ff           <= ESC_NONE;
         high_nibble_ff   <= '0;
         key_has_chars_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (pop_fire) begin
            value_phase_ff   <= value_phase_in;
            esc_ff           <= esc_in;
            high_nibble_ff   <= high_nibble_in;
            key_has_chars_ff <= key_has_chars_in;
            char_valid_ff    <= emit;
            char_out_ff      <= ch;
            in_value_ff      <= tag;
            pair_end_ff      <= pair;
         end
         if (pop_ready) begin
            rsp_valid_ff <= pop_valid && (emit || pair);
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.char_valid = char_valid_ff;
   assign rsp_if.char_out   = char_out_ff;
   assign rsp_if.in_value   = in_value_ff;
   assign rsp_if.pair_end   = pair_end_ff;

   a_rsp_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_valid_ff || pair_end_ff))
      else $error("Response transaction carries neither a character nor a pair end.");

   a_no_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !char_valid_ff) |-> (char_out_ff == '0 && !in_value_ff))
      else $error("Character fields are not cleared when no character is sent.");

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (pop_fire && pop_item.is_last) |=>
         (!value_phase_ff && esc_ff == ESC_NONE && !key_has_chars_ff))
      else $error("Decoder state was not cleared after the last byte.");

endmodule

// File: tb/url_form_pair_decoder_test.sv
// Self-checking testbench for url_form_pair_decoder: directed and random form strings with
// random idling on both channels, checked against a behavioural decoder kept in the bench.
// Depends on ufpd_pkg, ufpd_req_if, ufpd_rsp_if and url_form_pair_decoder.
module url_form_pair_decoder_test;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 550;

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_HIGH,
      ESC_LOW
   } esc_stage_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] char_out;
      logic       in_value;
      logic       pair_end;
   } decoded_type;

   typedef struct {
      logic [7:0]  in_byte;
      logic        is_last;
      logic        typed;
      logic        produces;
      decoded_type want;
   } step_row_type;

   localparam decoded_type NO_RESULT = '0;
   localparam decoded_type PAIR_ONLY = '{1'b0, 8'h00, 1'b0, 1'b1};

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufpd_req_if req_ch();
   ufpd_rsp_if rsp_ch();

   url_form_pair_decoder u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // Rows with typed set carry their expected transaction; the rest use the decoder below.
   step_row_type directed_steps [0:25] = '{
      '{"a",                  1'b0, 1'b1, 1'b1, '{1'b1, "a", 1'b0, 1'b0}},
      '{ufpd_pkg::CH_EQUAL,   1'b0, 1'b1, 1'b0, NO_RESULT},
      '{"b",                  1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_EQUAL,   1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_AMP,     1'b0, 1'b1, 1'b1, PAIR_ONLY},
      '{ufpd_pkg::CH_AMP,     1'b0, 1'b1, 1'b1, PAIR_ONLY},
      '{ufpd_pkg::CH_PLUS,    1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_PERCENT, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{"F",                  1'b0, 1'b1, 1'b0, NO_RESULT},
      '{"f",                  1'b0, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0}},
      '{ufpd_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{"g",                  1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_PLUS,    1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{"4",                  1'b0, 1'b0, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_EQUAL,   1'b0, 1'b0, 1'b0, NO_RESULT},
      '{"1",                  1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00,                1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF,                1'b1, 1'b1, 1'b1, '{1'b1, 8'hFF, 1'b1, 1'b1}},
      '{ufpd_pkg::CH_EQUAL,   1'b1, 1'b1, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_PERCENT, 1'b1, 1'b1, 1'b0, NO_RESULT},
      '{ufpd_pkg::CH_AMP,     1'b1, 1'b1, 1'b1, PAIR_ONLY},
      '{ufpd_pkg::CH_PERCENT, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{"0",                  1'b0, 1'b0, 1'b0, NO_RESULT},
      '{"0",                  1'b1, 1'b0, 1'b0, NO_RESULT}
   };

   decoded_type pending_decodes[$];
   logic [7:0]  form_text[$];

   logic          dec_value_phase;
   esc_stage_type dec_esc;
   logic [3:0]    dec_high;
   logic          dec_key_nonempty;

   int failures    = 0;
   int cycle_count = 0;
   int req_calm    = 0;
   int rsp_calm    = 0;

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return 4'(b - 8'h30);
      if (b >= 8'h41 && b <= 8'h46) return 4'(b - 8'h41 + 8'd10);
      if (b >= 8'h61 && b <= 8'h66) return 4'(b - 8'h61 + 8'd10);
      return 4'd0;
   endfunction

   function void clear_decoder();
      dec_value_phase  = 1'b0;
      dec_esc          = ESC_IDLE;
      dec_high         = 4'd0;
      dec_key_nonempty = 1'b0;
   endfunction

   function void decode_byte(input logic [7:0] b, input logic last,
                             output logic produced, output decoded_type d);
      d = NO_RESULT;
      if (!dec_value_phase && b == ufpd_pkg::CH_EQUAL) begin
         dec_value_phase = 1'b1;
      end else if (b == ufpd_pkg::CH_AMP) begin
         dec_value_phase  = 1'b0;
         dec_key_nonempty = 1'b0;
         d.pair_end       = 1'b1;
      end else if (b == ufpd_pkg::CH_PERCENT) begin
         dec_esc = ESC_HIGH;
      end else if (dec_esc == ESC_HIGH) begin
         dec_high = nibble_of(b);
         dec_esc  = ESC_LOW;
      end else begin
         if (dec_esc == ESC_LOW) begin
            d.char_out = {dec_high, nibble_of(b)};
            dec_esc    = ESC_IDLE;
         end else if (b == ufpd_pkg::CH_PLUS) begin
            d.char_out = ufpd_pkg::CH_SPACE;
         end else begin
            d.char_out = b;
         end
         d.char_valid = 1'b1;
         d.in_value   = dec_value_phase;
         if (!dec_value_phase) dec_key_nonempty = 1'b1;
      end
      if (last) begin
         if (dec_key_nonempty) d.pair_end = 1'b1;
         clear_decoder();
      end
      produced = d.char_valid | d.pair_end;
   endfunction

   function void report_failure(input string msg);
      failures++;
      if (failures <= 10) $display("[%0d] %s", cycle_count, msg);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] plain_char();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 36) return 8'(8'h41 + r - 10);
      return 8'(8'h61 + r - 36);
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 3))
         0: return ufpd_pkg::CH_AMP;
         1: return ufpd_pkg::CH_EQUAL;
         2: return ufpd_pkg::CH_PERCENT;
         default: return ufpd_pkg::CH_PLUS;
      endcase
   endfunction

   function void add_byte(input logic [7:0] b);
      form_text = {form_text, b};
   endfunction

   function void add_token();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) begin
         add_byte(plain_char());
      end else if (r < 14) begin
         add_byte(ufpd_pkg::CH_PLUS);
      end else if (r < 18) begin
         add_byte(ufpd_pkg::CH_PERCENT);
         add_byte(hex_char(4'($urandom_range(0, 15))));
         add_byte(hex_char(4'($urandom_range(0, 15))));
      end else if (r < 19) begin
         add_byte(ufpd_pkg::CH_PERCENT);
         add_byte(hex_char(4'($urandom_range(0, 15))));
      end else begin
         add_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   // Mostly well-formed key=value lists with random content; about one string in five is noise.
   function void compose_form();
      int pairs;
      form_text.delete();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 3))
               0: add_byte(8'($urandom_range(0, 255)));
               1: add_byte(special_char());
               default: add_byte(plain_char());
            endcase
         end
      end else begin
         pairs = $urandom_range(1, 3);
         for (int p = 0; p < pairs; p++) begin
            if (p > 0) add_byte(ufpd_pkg::CH_AMP);
            repeat ($urandom_range(0, 4)) add_token();
            if ($urandom_range(0, 5) != 0) begin
               add_byte(ufpd_pkg::CH_EQUAL);
               repeat ($urandom_range(0, 4)) add_token();
            end
         end
         if ($urandom_range(0, 7) == 0) add_byte(ufpd_pkg::CH_AMP);
      end
      if (form_text.size() == 0) add_byte(plain_char());
   endfunction

   task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic produces, input decoded_type want);
      logic        produced;
      decoded_type d;
      repeat (draw_wait(req_calm)) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.is_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      decode_byte(b, last, produced, d);
      if (typed) begin
         produced = produces;
         d        = want;
      end
      if (produced) pending_decodes = {pending_decodes, d};
   endtask

   task automatic drain_decoder();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   initial begin
      int  random_sent;
      bit  paused;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      req_ch.is_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      clear_decoder();
      random_sent = 0;
      paused      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         put_byte(directed_steps[i].in_byte, directed_steps[i].is_last, directed_steps[i].typed,
                  directed_steps[i].produces, directed_steps[i].want);
      end
      drain_decoder();

      while (random_sent < RANDOM_BYTES) begin
         compose_form();
         foreach (form_text[i]) begin
            put_byte(form_text[i], i == form_text.size() - 1, 1'b0, 1'b0, NO_RESULT);
         end
         random_sent += form_text.size();
         if (!paused && random_sent >= RANDOM_BYTES / 2) begin
            drain_decoder();
            paused = 1'b1;
         end
      end

      drain_decoder();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("url_form_pair_decoder_test: PASS");
      end else begin
         $display("url_form_pair_decoder_test: FAIL");
      end
      $finish;
   end

   initial begin
      decoded_type got;
      decoded_type want;
      wait (!reset);
      forever begin
         repeat (draw_wait(rsp_calm)) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = '{rsp_ch.char_valid, rsp_ch.char_out, rsp_ch.in_value, rsp_ch.pair_end};
         if (pending_decodes.size() == 0) begin
            report_failure($sformatf(
               "unexpected transaction: got %0b/%02h/%0b/%0b (valid/char/value/pair)",
               got.char_valid, got.char_out, got.in_value, got.pair_end));
         end else begin
            want = pending_decodes.pop_front();
            if (got.char_valid !== want.char_valid || got.char_out !== want.char_out ||
                got.in_value !== want.in_value || got.pair_end !== want.pair_end) begin
               report_failure($sformatf(
                  "mismatch: expected %0b/%02h/%0b/%0b, got %0b/%02h/%0b/%0b",
                  want.char_valid, want.char_out, want.in_value, want.pair_end,
                  got.char_valid, got.char_out, got.in_value, got.pair_end));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("url_form_pair_decoder_test: FAIL");
         $finish;
      end
   end

endmodule
